>>> hw/rtl/urs_pkg.sv
// shared types and constants for the undo/redo stack pair
package urs_pkg;

    localparam int DATA_W         = 32;
    localparam int MAIN_DEPTH_DEF = 8;

    typedef enum logic [2:0] {
        ACT_PUSH        = 3'd0,
        ACT_UNDO        = 3'd1,
        ACT_REDO        = 3'd2,
        ACT_CLEAR_MAIN  = 3'd3,
        ACT_CLEAR_SEC   = 3'd4,
        ACT_PEEK_MAIN   = 3'd5,
        ACT_PEEK_SEC    = 3'd6
    } t_action;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_MAIN_FULL   = 3'd1,
        ST_MAIN_EMPTY  = 3'd2,
        ST_SEC_FULL    = 3'd3,
        ST_SEC_EMPTY   = 3'd4
    } t_status;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_stk_ctrl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_stk_stat;

endpackage

>>> hw/rtl/undo_redo_stack_pair.sv
// top level: undo/redo stack pair with input register and result register
// a request is held in the input register until the result register can take its result
// throughput: one request per cycle while the output is not stalled
// stack tops are cached in registers so each action decodes from counts and tops
// reset clears both fill counts and all valid flags; stored words are not cleared
module undo_redo_stack_pair #(
    parameter int MAIN_DEPTH = urs_pkg::MAIN_DEPTH_DEF,
    localparam int SEC_DEPTH = 2 * MAIN_DEPTH,
    localparam int MCW       = $clog2(MAIN_DEPTH + 1),
    localparam int SCW       = $clog2(SEC_DEPTH + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [2:0]                        i_action,
    input  logic signed [urs_pkg::DATA_W-1:0] i_push_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output urs_pkg::t_status                  o_status,
    output logic signed [urs_pkg::DATA_W-1:0] o_top_value,
    output logic [MCW-1:0]                    o_main_fill,
    output logic [SCW-1:0]                    o_second_fill
);
    import urs_pkg::*;

    logic                     r_in_valid;
    t_action                  r_in_action;
    logic signed [DATA_W-1:0] r_in_value;

    logic                     r_out_valid;
    t_status                  r_status;
    logic signed [DATA_W-1:0] r_top_value;
    logic [MCW-1:0]           r_main_fill;
    logic [SCW-1:0]           r_second_fill;

    logic                     out_adv;
    logic                     proceed;
    logic                     in_take;

    t_stk_ctrl                main_ctrl;
    t_stk_ctrl                sec_ctrl;
    t_stk_stat                main_stat;
    t_stk_stat                sec_stat;
    logic signed [DATA_W-1:0] main_data;
    logic signed [DATA_W-1:0] main_top;
    logic signed [DATA_W-1:0] sec_top;
    logic [MCW-1:0]           main_count_next;
    logic [SCW-1:0]           sec_count_next;

    t_status                  n_status;
    logic signed [DATA_W-1:0] n_top_value;
    logic                     act_main_push;
    logic                     act_main_pop;
    logic                     act_main_clear;
    logic                     act_sec_push;
    logic                     act_sec_pop;
    logic                     act_sec_clear;
    logic                     from_sec;

    assign out_adv = !r_out_valid || !i_stall;
    assign proceed = r_in_valid && out_adv;
    assign o_stall = r_in_valid && !out_adv;
    assign in_take = i_valid && !o_stall;

    // decode the held request against current full/empty flags
    always_comb begin
        n_status       = ST_OK;
        n_top_value    = '0;
        act_main_push  = 1'b0;
        act_main_pop   = 1'b0;
        act_main_clear = 1'b0;
        act_sec_push   = 1'b0;
        act_sec_pop    = 1'b0;
        act_sec_clear  = 1'b0;
        from_sec       = 1'b0;
        unique case (r_in_action)
            ACT_PUSH: begin
                if (main_stat.full) begin
                    n_status = ST_MAIN_FULL;
                end else begin
                    act_main_push = 1'b1;
                    n_top_value   = r_in_value;
                end
            end
            ACT_UNDO: begin
                if (main_stat.empty) begin
                    n_status = ST_MAIN_EMPTY;
                end else if (sec_stat.full) begin
                    n_status = ST_SEC_FULL;
                end else begin
                    act_main_pop = 1'b1;
                    act_sec_push = 1'b1;
                    n_top_value  = main_top;
                end
            end
            ACT_REDO: begin
                if (sec_stat.empty) begin
                    n_status = ST_SEC_EMPTY;
                end else if (main_stat.full) begin
                    n_status = ST_MAIN_FULL;
                end else begin
                    act_sec_pop   = 1'b1;
                    act_main_push = 1'b1;
                    from_sec      = 1'b1;
                    n_top_value   = sec_top;
                end
            end
            ACT_CLEAR_MAIN: begin
                if (main_stat.empty) begin
                    n_status = ST_MAIN_EMPTY;
                end else begin
                    act_main_clear = 1'b1;
                end
            end
            ACT_CLEAR_SEC: begin
                if (sec_stat.empty) begin
                    n_status = ST_SEC_EMPTY;
                end else begin
                    act_sec_clear = 1'b1;
                end
            end
            ACT_PEEK_MAIN: begin
                if (main_stat.empty) begin
                    n_status = ST_MAIN_EMPTY;
                end else begin
                    n_top_value = main_top;
                end
            end
            ACT_PEEK_SEC: begin
                if (sec_stat.empty) begin
                    n_status = ST_SEC_EMPTY;
                end else begin
                    n_top_value = sec_top;
                end
            end
            default: begin
                // unused code leaves everything as is
                n_status = ST_OK;
            end
        endcase
    end

    assign main_ctrl.push  = proceed && act_main_push;
    assign main_ctrl.pop   = proceed && act_main_pop;
    assign main_ctrl.clear = proceed && act_main_clear;
    assign sec_ctrl.push   = proceed && act_sec_push;
    assign sec_ctrl.pop    = proceed && act_sec_pop;
    assign sec_ctrl.clear  = proceed && act_sec_clear;
    assign main_data       = from_sec ? sec_top : r_in_value;

    urs_stack #(
        .DEPTH (MAIN_DEPTH)
    ) u_main (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (main_ctrl),
        .i_data       (main_data),
        .o_count_next (main_count_next),
        .o_top        (main_top),
        .o_stat       (main_stat)
    );

    urs_stack #(
        .DEPTH (SEC_DEPTH)
    ) u_sec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (sec_ctrl),
        .i_data       (main_top),
        .o_count_next (sec_count_next),
        .o_top        (sec_top),
        .o_stat       (sec_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (proceed) begin
                r_in_valid <= 1'b0;
            end
            if (proceed) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_action <= t_action'(i_action);
            r_in_value  <= i_push_value;
        end
        if (proceed) begin
            r_status      <= n_status;
            r_top_value   <= n_top_value;
            r_main_fill   <= main_count_next;
            r_second_fill <= sec_count_next;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_top_value   = r_top_value;
    assign o_main_fill   = r_main_fill;
    assign o_second_fill = r_second_fill;

endmodule

>>> hw/rtl/urs_stack.sv
// one register-file stack with a cached top entry and fill count
module urs_stack #(
    parameter int DEPTH = urs_pkg::MAIN_DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  urs_pkg::t_stk_ctrl               i_ctrl,
    input  logic signed [urs_pkg::DATA_W-1:0] i_data,
    output logic [CW-1:0]                    o_count_next,
    output logic signed [urs_pkg::DATA_W-1:0] o_top,
    output urs_pkg::t_stk_stat               o_stat
);
    import urs_pkg::*;

    logic signed [DATA_W-1:0] r_store [DEPTH];
    logic signed [DATA_W-1:0] r_top;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic [AW-1:0]            below_idx;

    always_comb begin
        n_count = r_count;
        if (i_ctrl.clear) begin
            n_count = '0;
        end else if (i_ctrl.push) begin
            n_count = r_count + CW'(1);
        end else if (i_ctrl.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    // entry just under the top, becomes the top after a pop
    assign below_idx = r_count[AW-1:0] - AW'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_store[r_count[AW-1:0]] <= i_data;
            r_top                    <= i_data;
        end else if (i_ctrl.pop) begin
            r_top <= r_store[below_idx];
        end
    end

    assign o_count_next = n_count;
    assign o_top        = r_top;
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule
